// ===== rtl/core/cfp_pkg.sv =====
// Shared types, codes and helper functions for the command frame parser.
// No dependencies; every other file in the block refers to it by scoped names.

package cfp_pkg;

    // Default width of the timestamp arithmetic (gap taken modulo 2^TIME_BITS).
    localparam int TIME_BITS_DEFAULT = 32;

    // APB address width: six 32-bit registers at byte offsets 0 to 20.
    localparam int ADDR_W = 5;

    // Fixed frame constants.
    localparam logic [7:0] HEADER_BYTE = 8'hAA;

    // Opcodes of the command set.
    localparam logic [7:0] OPCODE_01 = 8'h01;
    localparam logic [7:0] OPCODE_81 = 8'h81;
    localparam logic [7:0] OPCODE_82 = 8'h82;
    localparam logic [7:0] OPCODE_83 = 8'h83;
    localparam logic [7:0] OPCODE_21 = 8'h21;
    localparam logic [7:0] OPCODE_22 = 8'h22;

    // Reset values of the configuration registers.
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4104;
    localparam logic [15:0] CRC_POLY_RESET    = 16'h8005;
    localparam logic [15:0] CRC_INIT_RESET    = 16'hFFFF;
    localparam logic        CRC_REFLECT_RESET = 1'b1;
    localparam logic [15:0] CRC_XOROUT_RESET  = 16'h0000;

    // Error codes reported with each result.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
    localparam logic [2:0] ERR_BAD_OPCODE = 3'd2;
    localparam logic [2:0] ERR_LENGTH     = 3'd3;
    localparam logic [2:0] ERR_CRC        = 3'd4;

    // Phase codes as seen on the result channel.
    localparam logic [2:0] PHASE_CODE_HEADER  = 3'd0;
    localparam logic [2:0] PHASE_CODE_OPCODE  = 3'd1;
    localparam logic [2:0] PHASE_CODE_LENGTH  = 3'd2;
    localparam logic [2:0] PHASE_CODE_PAYLOAD = 3'd3;
    localparam logic [2:0] PHASE_CODE_CRC     = 3'd4;

    // Configuration register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_GAP_TIMEOUT = 3'd0,
        REG_MAX_PAYLOAD = 3'd1,
        REG_CRC_POLY    = 3'd2,
        REG_CRC_INIT    = 3'd3,
        REG_CRC_REFLECT = 3'd4,
        REG_CRC_XOROUT  = 3'd5
    } cfg_index_t;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_OPCODE  = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } phase_t;

    // One received byte with its arrival time.
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } cfp_in_t;

    // One result per received byte.
    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  error_code;
        logic        timeout_abort;
        logic [7:0]  frame_opcode;
        logic [15:0] frame_payload_len;
        logic        payload_valid;
        logic [7:0]  payload_data;
        logic [15:0] payload_offset;
        logic [2:0]  parse_phase;
    } cfp_out_t;

    // Bit reversal of a byte.
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Bit reversal of a 16-bit word.
    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15 - i];
        end
        return r;
    endfunction

    // One byte through the MSB-first CRC-16 register, eight shift steps.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly,
                                               input logic        reflect);
        logic [7:0]  d;
        logic [15:0] c;
        d = reflect ? rev8(data) : data;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // The set of opcodes that the parser accepts.
    function automatic logic opcode_allowed(input logic [7:0] op);
        return (op == OPCODE_01) || (op == OPCODE_81) || (op == OPCODE_82) ||
               (op == OPCODE_83) || (op == OPCODE_21) || (op == OPCODE_22);
    endfunction

endpackage

// ===== rtl/core/command_frame_parser.sv =====
// Command frame parser top level: APB register file, input register, parser and result register.
// Depends on cfp_pkg for types, codes and the CRC helper functions.
//
// Usage
//   Received bytes enter on the s_ channel (valid/ready), each with its millisecond arrival
//   time. Every accepted byte gives exactly one result on the m_ channel: frame acceptance,
//   error code, timeout abort, the current opcode and length, a streamed payload byte with
//   its offset, and the phase after the byte.
//   A request is taken into an input register, parsed by one pass of logic (gap check,
//   phase update and an eight-step byte-wide CRC-16 update), and the result is held in an
//   output register, from which it is offered on m_valid and m_data.
//   Throughput is one byte per cycle while the receiver keeps m_ready high; the CRC byte
//   update and the timestamp subtract-and-compare are combinational, which allows this rate.
//   When the receiver stalls, the output register holds its result and the input register
//   holds one more byte; s_ready falls only when both are full.
//   The six configuration registers sit on the APB port at byte offsets 0 to 20 and the user
//   is to write them only while the block is idle; the block itself does not enforce this.
//   Synchronous active-low reset returns the parser to header phase, loads the register
//   defaults and empties both pipeline registers.

module command_frame_parser #(
    parameter int TIME_BITS = cfp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // byte input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cfp_pkg::cfp_in_t          s_data,
    // result output
    output logic                      m_valid,
    input  logic                      m_ready,
    output cfp_pkg::cfp_out_t         m_data,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int LAST_W = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [63:0] TIME_MASK =
        (TIME_BITS >= 64) ? {64{1'b1}} : ((64'd1 << TIME_BITS) - 64'd1);

    // Configuration registers
    logic [15:0] gap_timeout_reg;
    logic [15:0] max_payload_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;
    logic        crc_reflect_reg;
    logic [15:0] crc_xorout_reg;

    cfp_pkg::cfg_index_t cfg_idx;
    logic                cfg_write;

    // Pipeline registers
    logic              in_valid_reg;
    cfp_pkg::cfp_in_t  in_data_reg;
    logic              out_valid_reg;
    cfp_pkg::cfp_out_t out_data_reg;
    logic              advance;
    logic              process;

    // Parser state
    cfp_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     byte_count_reg, byte_count_next;
    logic [7:0]      opcode_reg, opcode_next;
    logic [15:0]     length_reg, length_next;
    logic [15:0]     crc_accum_reg, crc_accum_next;
    logic [7:0]      crc_low_reg, crc_low_next;
    logic [LAST_W-1:0] last_arrival_reg, last_arrival_next;

    cfp_pkg::cfp_out_t result_next;

    // APB decode: the register index is the word address.
    assign pready    = 1'b1;
    assign cfg_idx   = cfp_pkg::cfg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_timeout_reg <= cfp_pkg::GAP_TIMEOUT_RESET;
            max_payload_reg <= cfp_pkg::MAX_PAYLOAD_RESET;
            crc_poly_reg    <= cfp_pkg::CRC_POLY_RESET;
            crc_init_reg    <= cfp_pkg::CRC_INIT_RESET;
            crc_reflect_reg <= cfp_pkg::CRC_REFLECT_RESET;
            crc_xorout_reg  <= cfp_pkg::CRC_XOROUT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                cfp_pkg::REG_GAP_TIMEOUT: gap_timeout_reg <= pwdata[15:0];
                cfp_pkg::REG_MAX_PAYLOAD: max_payload_reg <= pwdata[15:0];
                cfp_pkg::REG_CRC_POLY:    crc_poly_reg    <= pwdata[15:0];
                cfp_pkg::REG_CRC_INIT:    crc_init_reg    <= pwdata[15:0];
                cfp_pkg::REG_CRC_REFLECT: crc_reflect_reg <= pwdata[0];
                cfp_pkg::REG_CRC_XOROUT:  crc_xorout_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            cfp_pkg::REG_GAP_TIMEOUT: prdata = {16'h0, gap_timeout_reg};
            cfp_pkg::REG_MAX_PAYLOAD: prdata = {16'h0, max_payload_reg};
            cfp_pkg::REG_CRC_POLY:    prdata = {16'h0, crc_poly_reg};
            cfp_pkg::REG_CRC_INIT:    prdata = {16'h0, crc_init_reg};
            cfp_pkg::REG_CRC_REFLECT: prdata = {31'h0, crc_reflect_reg};
            cfp_pkg::REG_CRC_XOROUT:  prdata = {16'h0, crc_xorout_reg};
            default:                  prdata = 32'h0;
        endcase
    end

    // Handshake: the parser moves a byte on whenever the result register is free or draining.
    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Parser: gap check, then one step of the frame state machine for the held byte.
    always_comb begin
        logic [63:0]     now64;
        logic [63:0]     last64;
        logic [63:0]     gap;
        logic            timed_out;
        logic [7:0]      b;
        logic [15:0]     count_inc;
        logic [15:0]     rx_crc;
        logic [15:0]     calc_crc;
        logic [15:0]     full_len;
        cfp_pkg::phase_t ph;

        b      = in_data_reg.rx_byte;
        now64  = {32'h0, in_data_reg.now_ms};
        last64 = {{(64 - LAST_W){1'b0}}, last_arrival_reg};
        gap    = (now64 - last64) & TIME_MASK;
        timed_out = gap > {48'h0, gap_timeout_reg};

        ph                = phase_reg;
        byte_count_next   = byte_count_reg;
        opcode_next       = opcode_reg;
        length_next       = length_reg;
        crc_accum_next    = crc_accum_reg;
        crc_low_next      = crc_low_reg;
        last_arrival_next = in_data_reg.now_ms[LAST_W-1:0];
        count_inc         = byte_count_reg + 16'd1;
        rx_crc            = {b, crc_low_reg};
        calc_crc          = (crc_reflect_reg ? cfp_pkg::rev16(crc_accum_reg) : crc_accum_reg)
                            ^ crc_xorout_reg;
        full_len          = {b, length_reg[7:0]};

        result_next = '0;

        // A long gap drops any partial frame before the byte is parsed.
        if (timed_out) begin
            result_next.timeout_abort = (phase_reg != cfp_pkg::PH_HEADER);
            ph              = cfp_pkg::PH_HEADER;
            byte_count_next = 16'd0;
            count_inc       = 16'd1;
        end
        phase_next = ph;

        unique case (ph)
            cfp_pkg::PH_HEADER: begin
                if (b == cfp_pkg::HEADER_BYTE) begin
                    crc_accum_next  = cfp_pkg::crc16_feed(crc_init_reg, b, crc_poly_reg,
                                                          crc_reflect_reg);
                    byte_count_next = 16'd0;
                    phase_next      = cfp_pkg::PH_OPCODE;
                end else begin
                    result_next.error_code = cfp_pkg::ERR_BAD_HEADER;
                end
            end
            cfp_pkg::PH_OPCODE: begin
                if (cfp_pkg::opcode_allowed(b)) begin
                    opcode_next     = b;
                    crc_accum_next  = cfp_pkg::crc16_feed(crc_accum_reg, b, crc_poly_reg,
                                                          crc_reflect_reg);
                    byte_count_next = 16'd0;
                    phase_next      = cfp_pkg::PH_LENGTH;
                end else begin
                    result_next.error_code = cfp_pkg::ERR_BAD_OPCODE;
                    phase_next             = cfp_pkg::PH_HEADER;
                end
            end
            cfp_pkg::PH_LENGTH: begin
                crc_accum_next = cfp_pkg::crc16_feed(crc_accum_reg, b, crc_poly_reg,
                                                     crc_reflect_reg);
                if (byte_count_next == 16'd0) begin
                    length_next     = {8'h00, b};
                    byte_count_next = 16'd1;
                end else begin
                    length_next     = full_len;
                    byte_count_next = 16'd0;
                    if (full_len > max_payload_reg) begin
                        result_next.error_code = cfp_pkg::ERR_LENGTH;
                        phase_next             = cfp_pkg::PH_HEADER;
                    end else if (full_len != 16'd0) begin
                        phase_next = cfp_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = cfp_pkg::PH_CRC;
                    end
                end
            end
            cfp_pkg::PH_PAYLOAD: begin
                crc_accum_next = cfp_pkg::crc16_feed(crc_accum_reg, b, crc_poly_reg,
                                                     crc_reflect_reg);
                result_next.payload_valid  = 1'b1;
                result_next.payload_data   = b;
                result_next.payload_offset = byte_count_next;
                byte_count_next            = count_inc;
                if (count_inc >= length_reg) begin
                    byte_count_next = 16'd0;
                    phase_next      = cfp_pkg::PH_CRC;
                end
            end
            cfp_pkg::PH_CRC: begin
                if (byte_count_next == 16'd0) begin
                    crc_low_next    = b;
                    byte_count_next = 16'd1;
                end else begin
                    if (rx_crc == calc_crc) begin
                        result_next.frame_ok = 1'b1;
                    end else begin
                        result_next.error_code = cfp_pkg::ERR_CRC;
                    end
                    byte_count_next = 16'd0;
                    phase_next      = cfp_pkg::PH_HEADER;
                end
            end
            default: begin
                phase_next = cfp_pkg::PH_HEADER;
            end
        endcase

        result_next.frame_opcode      = opcode_next;
        result_next.frame_payload_len = length_next;

        // Phase after the byte, in the code used on the result channel.
        unique case (phase_next)
            cfp_pkg::PH_HEADER:  result_next.parse_phase = cfp_pkg::PHASE_CODE_HEADER;
            cfp_pkg::PH_OPCODE:  result_next.parse_phase = cfp_pkg::PHASE_CODE_OPCODE;
            cfp_pkg::PH_LENGTH:  result_next.parse_phase = cfp_pkg::PHASE_CODE_LENGTH;
            cfp_pkg::PH_PAYLOAD: result_next.parse_phase = cfp_pkg::PHASE_CODE_PAYLOAD;
            cfp_pkg::PH_CRC:     result_next.parse_phase = cfp_pkg::PHASE_CODE_CRC;
            default:             result_next.parse_phase = cfp_pkg::PHASE_CODE_HEADER;
        endcase
    end

    // Parser state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= cfp_pkg::PH_HEADER;
            byte_count_reg   <= 16'd0;
            opcode_reg       <= 8'h00;
            length_reg       <= 16'd0;
            crc_accum_reg    <= cfp_pkg::CRC_INIT_RESET;
            crc_low_reg      <= 8'h00;
            last_arrival_reg <= '0;
        end else if (process) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            opcode_reg       <= opcode_next;
            length_reg       <= length_next;
            crc_accum_reg    <= crc_accum_next;
            crc_low_reg      <= crc_low_next;
            last_arrival_reg <= last_arrival_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_data_reg <= result_next;
        end
    end

    // A byte taken by the parser appears as a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) process |=> m_valid)
        else $error("parsed byte did not reach the result register");

    // A payload byte leaves the parser in payload or CRC phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.payload_valid) |->
        (m_data.parse_phase == cfp_pkg::PHASE_CODE_PAYLOAD ||
         m_data.parse_phase == cfp_pkg::PHASE_CODE_CRC))
        else $error("payload byte reported outside payload phase");

    // An accepted frame carries no error and returns the parser to header phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_ok) |->
        (m_data.error_code == cfp_pkg::ERR_NONE &&
         m_data.parse_phase == cfp_pkg::PHASE_CODE_HEADER))
        else $error("frame accepted with an error or outside header phase");

endmodule
